### src/glmct_pkg.sv
package glmct_pkg;

	localparam int GRID_SIDE  = 256;
	localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
	localparam int ADDR_W     = $clog2(GRID_CELLS);

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_TRACE = 1'b1;

	// Inscribed, lethal and unknown all block a line.
	localparam logic [7:0] CELL_BLOCK_MIN = 8'd253;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic  req_type;
		byte_t start_x;
		byte_t start_y;
		byte_t end_x;
		byte_t end_y;
		byte_t cell_value;
	} cmd_t;

	typedef struct packed {
		logic  blocked;
		byte_t max_cost;
	} result_t;

	// Classified operation passed from the front to the back.
	typedef struct packed {
		logic  is_query;
		byte_t x0;
		byte_t y0;
		byte_t value;
		byte_t den;
		byte_t add;
		byte_t count;
		logic  x_neg;
		logic  y_neg;
		logic  x_major;
	} op_t;

endpackage

### src/glmct_front.sv
module glmct_front (
	input  glmct_pkg::cmd_t cmd,
	output glmct_pkg::op_t  op
);
	import glmct_pkg::*;

	byte_t dx;
	byte_t dy;
	logic  x_neg;
	logic  y_neg;
	logic  x_major;

	always_comb begin
		x_neg   = cmd.end_x < cmd.start_x;
		y_neg   = cmd.end_y < cmd.start_y;
		dx      = x_neg ? (cmd.start_x - cmd.end_x) : (cmd.end_x - cmd.start_x);
		dy      = y_neg ? (cmd.start_y - cmd.end_y) : (cmd.end_y - cmd.start_y);
		// On a tie the column is the major axis.
		x_major = dx >= dy;

		op.is_query = cmd.req_type == REQ_TRACE;
		op.x0       = cmd.start_x;
		op.y0       = cmd.start_y;
		op.value    = cmd.cell_value;
		op.den      = x_major ? dx : dy;
		op.add      = x_major ? dy : dx;
		op.count    = x_major ? dx : dy;
		op.x_neg    = x_neg;
		op.y_neg    = y_neg;
		op.x_major  = x_major;
	end

endmodule

### src/glmct_fifo.sv
module glmct_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  glmct_pkg::op_t push_op,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output glmct_pkg::op_t head_op
);
	import glmct_pkg::*;

	op_t                q_mem [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               do_push;
	logic               do_pop;

	function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
		logic [Q_PTR_W-1:0] r;
		r = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
		return r;
	endfunction

	assign full      = cnt_q == Q_CNT_W'(Q_DEPTH);
	assign not_empty = cnt_q != '0;
	assign head_op   = q_mem[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + Q_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - Q_CNT_W'(1);
			end
		end
	end

endmodule

### src/glmct_back.sv
module glmct_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                op_valid,
	input  glmct_pkg::op_t      op,
	output logic                op_pop,
	output logic                done,
	output glmct_pkg::result_t  result
);
	import glmct_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} walk_state_t;

	byte_t       cost_grid [GRID_CELLS];

	walk_state_t state_q;
	logic        issue_on_q;
	logic        done_q;
	logic        rd_vld_s1;
	logic        rd_last_s1;
	logic        rd_oob_s1;
	byte_t       rd_data_s1;

	byte_t       x_q;
	byte_t       y_q;
	logic [8:0]  acc_q;
	byte_t       rem_q;
	byte_t       den_q;
	byte_t       add_q;
	logic        x_neg_q;
	logic        y_neg_q;
	logic        x_major_q;
	byte_t       best_q;
	result_t     result_q;

	logic              cell_blk;
	logic              finish;
	logic              issue;
	byte_t             best_nxt;
	logic [8:0]        acc_sum;
	logic              minor;
	logic [8:0]        acc_nxt;
	byte_t             x_nxt;
	byte_t             y_nxt;
	logic [ADDR_W-1:0] rd_addr;
	logic              rd_oob;
	logic [ADDR_W-1:0] wr_addr;
	logic              wr_en;

	always_comb begin
		cell_blk = rd_oob_s1 || (rd_data_s1 >= CELL_BLOCK_MIN);
		finish   = rd_vld_s1 && (cell_blk || rd_last_s1);
		issue    = (state_q == ST_WALK) && issue_on_q && !finish;
		op_pop   = (state_q == ST_IDLE) && op_valid;
		best_nxt = (rd_data_s1 > best_q) ? rd_data_s1 : best_q;

		acc_sum = acc_q + {1'b0, add_q};
		minor   = acc_sum >= {1'b0, den_q};
		acc_nxt = minor ? (acc_sum - {1'b0, den_q}) : acc_sum;
		x_nxt   = x_q + ((x_major_q || minor) ? (x_neg_q ? 8'hFF : 8'h01) : 8'h00);
		y_nxt   = y_q + ((!x_major_q || minor) ? (y_neg_q ? 8'hFF : 8'h01) : 8'h00);

		rd_addr = ADDR_W'(32'(y_q) * GRID_SIDE + 32'(x_q));
		rd_oob  = (32'(x_q) >= GRID_SIDE) || (32'(y_q) >= GRID_SIDE);
		wr_addr = ADDR_W'(32'(op.y0) * GRID_SIDE + 32'(op.x0));
		wr_en   = op_pop && !op.is_query
			&& (32'(op.x0) < GRID_SIDE) && (32'(op.y0) < GRID_SIDE);
	end

	// A cell outside the grid reads as unknown, which blocks the line.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			cost_grid[wr_addr] <= op.value;
		end
		rd_data_s1 <= cost_grid[rd_addr];
		rd_oob_s1  <= rd_oob;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			issue_on_q <= 1'b0;
			done_q     <= 1'b0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
		end else begin
			done_q     <= finish || (op_pop && !op.is_query);
			rd_vld_s1  <= issue;
			rd_last_s1 <= rem_q == '0;
			case (state_q)
				ST_IDLE: begin
					if (op_pop && op.is_query) begin
						state_q    <= ST_WALK;
						issue_on_q <= 1'b1;
					end
				end
				ST_WALK: begin
					if (issue && rem_q == '0) begin
						issue_on_q <= 1'b0;
					end
					if (finish) begin
						state_q    <= ST_IDLE;
						issue_on_q <= 1'b0;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					issue_on_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop && op.is_query) begin
			x_q       <= op.x0;
			y_q       <= op.y0;
			acc_q     <= {2'b00, op.den[7:1]};
			rem_q     <= op.count;
			den_q     <= op.den;
			add_q     <= op.add;
			x_neg_q   <= op.x_neg;
			y_neg_q   <= op.y_neg;
			x_major_q <= op.x_major;
			best_q    <= '0;
		end else begin
			if (issue) begin
				x_q   <= x_nxt;
				y_q   <= y_nxt;
				acc_q <= acc_nxt;
				rem_q <= rem_q - 8'd1;
			end
			if (rd_vld_s1 && !cell_blk) begin
				best_q <= best_nxt;
			end
		end
		if (op_pop && !op.is_query) begin
			result_q <= '0;
		end else if (finish) begin
			result_q.blocked  <= cell_blk;
			result_q.max_cost <= cell_blk ? 8'd0 : best_nxt;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### src/grid_line_max_cost_tracer_unit.sv
// A write's result goes to done once the back end pops it; a query of N line cells gives
// its result after its last cell read, earlier when a blocking cell ends the walk.
// A query makes one grid read per line cell from the cost memory, which has separate read
// and write ports; while the walker is busy, a two-entry queue takes new items.
// Reset clears control state only; the cost grid holds no defined value until written.
// Results are strobed on done for one cycle; the receiver cannot stall them.
module grid_line_max_cost_tracer_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  glmct_pkg::cmd_t    cmd,
	output logic               done,
	output glmct_pkg::result_t result
);
	import glmct_pkg::*;

	op_t  front_op;
	op_t  head_op;
	logic q_full;
	logic q_not_empty;
	logic q_pop;
	logic q_push;

	assign busy   = q_full;
	assign q_push = start && !q_full;

	glmct_front u_front (
		.cmd (cmd),
		.op  (front_op)
	);

	glmct_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_op   (front_op),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head_op   (head_op)
	);

	glmct_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (q_not_empty),
		.op       (head_op),
		.op_pop   (q_pop),
		.done     (done),
		.result   (result)
	);

endmodule
